>>> design/lrs_pkg.sv
// Shared types, codes and constants for the layout region stretch block.
package lrs_pkg;

    // Field widths of the item, result and configuration words
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 6;
    localparam int COORD_W  = 32;
    localparam int DIR_W    = 3;
    localparam int LABEL_W  = 6;
    localparam int AMOUNT_W = 32;
    localparam int CFG_W    = 7;

    // Output coordinates are clamped to this signed range
    localparam int COORD_BITS = 32;

    // Default table depths
    localparam int DEF_REGIONS = 64;
    localparam int DEF_LABELS  = 64;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_REGION = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LABEL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // Direction codes as they arrive on the item channel
    localparam logic [DIR_W-1:0] MOVE_UP    = 3'd1;
    localparam logic [DIR_W-1:0] MOVE_DOWN  = 3'd2;
    localparam logic [DIR_W-1:0] MOVE_LEFT  = 3'd3;
    localparam logic [DIR_W-1:0] MOVE_RIGHT = 3'd4;

    // One stored region
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] bottom;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] top;
        logic [DIR_W-1:0]          dir;
        logic [LABEL_W-1:0]        label;
    } t_region;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_ADD,
        ST_MINMAX,
        ST_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic take;     // item channel ready
        logic issue;    // read the next region entry
        logic add;      // form the moved corner coordinates
        logic minmax;   // rebuild the rectangle
        logic load_out; // move the result into the output register
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic item_valid;
        logic item_query;
        logic walk_done;
        logic pipe_empty;
        logic out_free;
    } t_ctrl_sts;

endpackage

>>> design/lrs_item_if.sv
// Item channel: command word with region, label or query payload.
interface lrs_item_if;
    logic                                valid;
    logic                                ready;
    logic [lrs_pkg::CMD_W-1:0]           cmd;
    logic [lrs_pkg::INDEX_W-1:0]         entry_index;
    logic signed [lrs_pkg::COORD_W-1:0]  x_low;
    logic signed [lrs_pkg::COORD_W-1:0]  y_low;
    logic signed [lrs_pkg::COORD_W-1:0]  x_high;
    logic signed [lrs_pkg::COORD_W-1:0]  y_high;
    logic [lrs_pkg::DIR_W-1:0]           direction;
    logic [lrs_pkg::LABEL_W-1:0]         label;
    logic signed [lrs_pkg::AMOUNT_W-1:0] amount;

    modport source (
        output valid, cmd, entry_index, x_low, y_low, x_high, y_high,
               direction, label, amount,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, x_low, y_low, x_high, y_high,
               direction, label, amount,
        output ready
    );
endinterface

>>> design/lrs_result_if.sv
// Result channel: the stretched rectangle.
interface lrs_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [lrs_pkg::COORD_W-1:0] out_x_low;
    logic signed [lrs_pkg::COORD_W-1:0] out_y_low;
    logic signed [lrs_pkg::COORD_W-1:0] out_x_high;
    logic signed [lrs_pkg::COORD_W-1:0] out_y_high;

    modport source (
        output valid, out_x_low, out_y_low, out_x_high, out_y_high,
        input  ready
    );
    modport sink (
        input  valid, out_x_low, out_y_low, out_x_high, out_y_high,
        output ready
    );
endinterface

>>> design/lrs_cfg_if.sv
// Configuration write channel: region count word.
interface lrs_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [lrs_pkg::CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> design/layout_region_stretch.sv
// Top level of the layout region stretch block.
//
// Three valid/ready channels. i_item carries command words: a region word
// stores one region entry, a label word stores one label amount, and a query
// word stretches a rectangle. o_result carries one word for each query and
// none for the writes. i_cfg writes the region count and is always ready.
// Region and label writes are stored when taken, from the idle state. A
// query reads the region table one entry per cycle over the first
// min(region_count, REGIONS) entries, through its single read port; the
// label read, the corner sums and the min/max follow as registered stages,
// and the clamp is applied as the result is loaded into the output register.
// One item is in work at a time; i_item.ready is high only between items.
// The result sits in an output register, so a stalled receiver holds the
// block only once a second query has finished while the first result waits.
// Reset clears the region count, the walk counter, the stage valids, the control state and the output valid;
// both tables stay undefined until written and need no clearing pass.
module layout_region_stretch #(
    parameter int REGIONS = lrs_pkg::DEF_REGIONS,
    parameter int LABELS  = lrs_pkg::DEF_LABELS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lrs_item_if.sink     i_item,
    lrs_cfg_if.sink      i_cfg,
    lrs_result_if.source o_result
);

    lrs_pkg::t_ctrl_cmd ctrl_cmd;
    lrs_pkg::t_ctrl_sts ctrl_sts;
    logic               cfg_we;

    // Configuration words are taken at once
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    lrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (ctrl_sts),
        .o_cmd   (ctrl_cmd)
    );

    lrs_dpath #(
        .REGIONS (REGIONS),
        .LABELS  (LABELS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .o_result   (o_result),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg.data),
        .i_cmd      (ctrl_cmd),
        .o_sts      (ctrl_sts)
    );

endmodule

>>> design/lrs_ctrl.sv
// Sequencing state machine for writes and stretch queries.
module lrs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lrs_pkg::t_ctrl_sts i_sts,
    output lrs_pkg::t_ctrl_cmd o_cmd
);

    lrs_pkg::t_state r_state;
    lrs_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lrs_pkg::ST_IDLE: begin
                if (i_sts.item_valid && i_sts.item_query) begin
                    n_state = lrs_pkg::ST_WALK;
                end
            end
            lrs_pkg::ST_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = lrs_pkg::ST_DRAIN;
                end
            end
            lrs_pkg::ST_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = lrs_pkg::ST_ADD;
                end
            end
            lrs_pkg::ST_ADD: begin
                n_state = lrs_pkg::ST_MINMAX;
            end
            lrs_pkg::ST_MINMAX: begin
                n_state = lrs_pkg::ST_OUT;
            end
            lrs_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    n_state = lrs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lrs_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            lrs_pkg::ST_IDLE:   o_cmd.take     = 1'b1;
            lrs_pkg::ST_WALK:   o_cmd.issue    = !i_sts.walk_done;
            lrs_pkg::ST_DRAIN:  o_cmd          = '0;
            lrs_pkg::ST_ADD:    o_cmd.add      = 1'b1;
            lrs_pkg::ST_MINMAX: o_cmd.minmax   = 1'b1;
            lrs_pkg::ST_OUT:    o_cmd.load_out = i_sts.out_free;
            default:            o_cmd          = '0;
        endcase
    end

endmodule

>>> design/lrs_dpath.sv
// Region and label tables, region walk pipeline, corner sums and output register.
module lrs_dpath #(
    parameter int REGIONS = lrs_pkg::DEF_REGIONS,
    parameter int LABELS  = lrs_pkg::DEF_LABELS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lrs_item_if.sink           i_item,
    lrs_result_if.source       o_result,
    input  logic               i_cfg_we,
    input  logic [lrs_pkg::CFG_W-1:0] i_cfg_data,
    input  lrs_pkg::t_ctrl_cmd i_cmd,
    output lrs_pkg::t_ctrl_sts o_sts
);

    localparam int CW    = lrs_pkg::COORD_W;
    localparam int RA_W  = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int LA_W  = (LABELS > 1) ? $clog2(LABELS) : 1;
    localparam int IDX_W = $clog2(REGIONS + 1);
    // Sum of up to REGIONS non-negative 32-bit amounts, plus sign
    localparam int ACC_W = lrs_pkg::AMOUNT_W + 1 + $clog2(REGIONS + 1);
    localparam int SUM_W = ACC_W + 1;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - lrs_pkg::COORD_BITS + 1){1'b0}}, {(lrs_pkg::COORD_BITS - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    // Tables
    lrs_pkg::t_region                   r_reg_mem [REGIONS];
    logic signed [lrs_pkg::AMOUNT_W-1:0] r_lab_mem [LABELS];

    logic [lrs_pkg::CFG_W-1:0] r_region_count;
    logic [IDX_W-1:0]          r_idx;
    logic [IDX_W-1:0]          walk_lim;

    logic signed [CW-1:0] r_q_xl, r_q_yl, r_q_xh, r_q_yh;

    // Walk pipeline
    logic                       r_v1, r_v2;
    lrs_pkg::t_region           r_rd;
    logic [3:0]                 corner_in;
    logic                       lab_ok, move, mv_x, mv_neg;
    logic [3:0]                 r_flags;
    logic                       r_lab_ok, r_move, r_mv_x, r_mv_neg;
    logic signed [lrs_pkg::AMOUNT_W-1:0] r_amt;
    logic signed [ACC_W-1:0]    delta;
    logic                       acc_en;
    logic signed [ACC_W-1:0]    r_dx [4];
    logic signed [ACC_W-1:0]    r_dy [4];

    // Finishing stages
    logic signed [SUM_W-1:0] r_sx [4];
    logic signed [SUM_W-1:0] r_sy [4];
    logic signed [SUM_W-1:0] r_ol, r_ob, r_or, r_ot;

    logic r_out_valid;
    logic signed [CW-1:0] r_out_xl, r_out_yl, r_out_xh, r_out_yh;

    logic accept;
    logic [31:0] w_reg_ext, w_lab_ext, rd_lab_ext, cnt_ext;

    // Clamp a wide coordinate to the output range
    function automatic logic signed [CW-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        begin
            c = v;
            if (v > SAT_HI) c = SAT_HI;
            if (v < SAT_LO) c = SAT_LO;
            sat = c[CW-1:0];
        end
    endfunction

    function automatic logic signed [SUM_W-1:0] cext(input logic signed [CW-1:0] v);
        cext = {{(SUM_W - CW){v[CW-1]}}, v};
    endfunction

    function automatic logic signed [SUM_W-1:0] aext(input logic signed [ACC_W-1:0] v);
        aext = {v[ACC_W-1], v};
    endfunction

    assign accept      = i_item.valid && i_cmd.take;
    assign i_item.ready = i_cmd.take;

    assign w_reg_ext  = 32'(i_item.entry_index);
    assign w_lab_ext  = 32'(i_item.entry_index);
    assign rd_lab_ext = 32'(r_rd.label);
    assign cnt_ext    = 32'(r_region_count);
    assign walk_lim   = (cnt_ext > 32'(REGIONS)) ? IDX_W'(REGIONS) : IDX_W'(r_region_count);

    // Status to the controller
    always_comb begin
        o_sts.item_valid = i_item.valid;
        o_sts.item_query = (i_item.cmd == lrs_pkg::CMD_QUERY);
        o_sts.walk_done  = (r_idx >= walk_lim);
        o_sts.pipe_empty = !r_v1 && !r_v2;
        o_sts.out_free   = !r_out_valid || o_result.ready;
    end

    // Region count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_count <= '0;
        end else if (i_cfg_we) begin
            r_region_count <= i_cfg_data;
        end
    end

    // Region table: written by a region word, read one entry per walk cycle
    always_ff @(posedge i_clk) begin
        if (accept && i_item.cmd == lrs_pkg::CMD_REGION && w_reg_ext < 32'(REGIONS)) begin
            r_reg_mem[w_reg_ext[RA_W-1:0]] <= '{
                left:   i_item.x_low,
                bottom: i_item.y_low,
                right:  i_item.x_high,
                top:    i_item.y_high,
                dir:    i_item.direction,
                label:  i_item.label
            };
        end
        if (i_cmd.issue) begin
            r_rd <= r_reg_mem[r_idx[RA_W-1:0]];
        end
    end

    // Label table: written by a label word, read with the label of the fetched region
    always_ff @(posedge i_clk) begin
        if (accept && i_item.cmd == lrs_pkg::CMD_LABEL && w_lab_ext < 32'(LABELS)) begin
            r_lab_mem[w_lab_ext[LA_W-1:0]] <= i_item.amount;
        end
        if (r_v1) begin
            r_amt <= r_lab_mem[rd_lab_ext[LA_W-1:0]];
        end
    end

    // Query latch and walk counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (accept && i_item.cmd == lrs_pkg::CMD_QUERY) begin
            r_idx <= '0;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_item.cmd == lrs_pkg::CMD_QUERY) begin
            r_q_xl <= i_item.x_low;
            r_q_yl <= i_item.y_low;
            r_q_xh <= i_item.x_high;
            r_q_yh <= i_item.y_high;
        end
    end

    // Corner containment and direction decode for the fetched region
    always_comb begin
        logic xl_in, xh_in, yl_in, yh_in;
        xl_in = (r_q_xl >= r_rd.left)   && (r_q_xl <= r_rd.right);
        xh_in = (r_q_xh >= r_rd.left)   && (r_q_xh <= r_rd.right);
        yl_in = (r_q_yl >= r_rd.bottom) && (r_q_yl <= r_rd.top);
        yh_in = (r_q_yh >= r_rd.bottom) && (r_q_yh <= r_rd.top);
        // corners: 0 low-left, 1 low-right, 2 high-left, 3 high-right
        corner_in = {xh_in && yh_in, xl_in && yh_in, xh_in && yl_in, xl_in && yl_in};
        lab_ok    = rd_lab_ext < 32'(LABELS);
        move   = 1'b1;
        mv_x   = 1'b0;
        mv_neg = 1'b0;
        unique case (r_rd.dir)
            lrs_pkg::MOVE_UP:    begin mv_x = 1'b0; mv_neg = 1'b0; end
            lrs_pkg::MOVE_DOWN:  begin mv_x = 1'b0; mv_neg = 1'b1; end
            lrs_pkg::MOVE_LEFT:  begin mv_x = 1'b1; mv_neg = 1'b1; end
            lrs_pkg::MOVE_RIGHT: begin mv_x = 1'b1; mv_neg = 1'b0; end
            default:             move = 1'b0;
        endcase
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    // Stage two: flags travel alongside the label amount
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_flags  <= corner_in;
            r_lab_ok <= lab_ok;
            r_move   <= move;
            r_mv_x   <= mv_x;
            r_mv_neg <= mv_neg;
        end
    end

    // Stage three: accumulate the non-negative amount, negated for down and left moves, into each contained corner
    assign acc_en = r_v2 && r_lab_ok && r_move && !r_amt[lrs_pkg::AMOUNT_W-1];
    always_comb begin
        logic signed [ACC_W-1:0] a;
        a     = {{(ACC_W - lrs_pkg::AMOUNT_W){r_amt[lrs_pkg::AMOUNT_W-1]}}, r_amt};
        delta = r_mv_neg ? -a : a;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            if (accept && i_item.cmd == lrs_pkg::CMD_QUERY) begin
                r_dx[i] <= '0;
                r_dy[i] <= '0;
            end else if (acc_en && r_flags[i]) begin
                if (r_mv_x) begin
                    r_dx[i] <= r_dx[i] + delta;
                end else begin
                    r_dy[i] <= r_dy[i] + delta;
                end
            end
        end
    end

    // Moved corner coordinates
    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_sx[0] <= cext(r_q_xl) + aext(r_dx[0]);
            r_sx[1] <= cext(r_q_xh) + aext(r_dx[1]);
            r_sx[2] <= cext(r_q_xl) + aext(r_dx[2]);
            r_sx[3] <= cext(r_q_xh) + aext(r_dx[3]);
            r_sy[0] <= cext(r_q_yl) + aext(r_dy[0]);
            r_sy[1] <= cext(r_q_yl) + aext(r_dy[1]);
            r_sy[2] <= cext(r_q_yh) + aext(r_dy[2]);
            r_sy[3] <= cext(r_q_yh) + aext(r_dy[3]);
        end
    end

    // Rebuild the rectangle from the moved corners
    always_ff @(posedge i_clk) begin
        if (i_cmd.minmax) begin
            r_ol <= (r_sx[0] < r_sx[2]) ? r_sx[0] : r_sx[2];
            r_or <= (r_sx[1] > r_sx[3]) ? r_sx[1] : r_sx[3];
            r_ob <= (r_sy[0] < r_sy[1]) ? r_sy[0] : r_sy[1];
            r_ot <= (r_sy[2] > r_sy[3]) ? r_sy[2] : r_sy[3];
        end
    end

    // Output register: holds the word until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_xl <= sat(r_ol);
            r_out_yl <= sat(r_ob);
            r_out_xh <= sat(r_or);
            r_out_yh <= sat(r_ot);
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.out_x_low  = r_out_xl;
    assign o_result.out_y_low  = r_out_yl;
    assign o_result.out_x_high = r_out_xh;
    assign o_result.out_y_high = r_out_yh;

endmodule
